/* rtl/sph_pkg.sv */
package sph_pkg;

   localparam int MAX_CODE_BITS = 32;

   typedef enum logic [5:0] {
      PH_SET_ID        = 6'd0,
      PH_CHROMA        = 6'd1,
      PH_SEP_PLANE     = 6'd2,
      PH_DEPTH_L       = 6'd3,
      PH_DEPTH_C       = 6'd4,
      PH_BYPASS        = 6'd5,
      PH_MATRIX        = 6'd6,
      PH_LIST_FLAG     = 6'd7,
      PH_DELTA         = 6'd8,
      PH_FRAME_NUM     = 6'd9,
      PH_POC_TYPE      = 6'd10,
      PH_POC_LSB       = 6'd11,
      PH_ALWAYS_ZERO   = 6'd12,
      PH_NONREF        = 6'd13,
      PH_TOPBOT        = 6'd14,
      PH_CYCLE_N       = 6'd15,
      PH_CYCLE_OFF     = 6'd16,
      PH_NUM_REF       = 6'd17,
      PH_GAPS          = 6'd18,
      PH_WIDTH         = 6'd19,
      PH_HEIGHT        = 6'd20,
      PH_FRAMES_ONLY   = 6'd21,
      PH_MBAFF         = 6'd22,
      PH_DIRECT        = 6'd23,
      PH_CROP_FLAG     = 6'd24,
      PH_CROP          = 6'd25,
      PH_VUI_FLAG      = 6'd26,
      PH_AR_FLAG       = 6'd27,
      PH_AR_IDC        = 6'd28,
      PH_SAR_W         = 6'd29,
      PH_SAR_H         = 6'd30,
      PH_OVERSCAN_FLAG = 6'd31,
      PH_OVERSCAN_APP  = 6'd32,
      PH_VST_FLAG      = 6'd33,
      PH_VIDEO_FMT     = 6'd34,
      PH_FULL_RANGE    = 6'd35,
      PH_COLOUR_FLAG   = 6'd36,
      PH_COLOUR        = 6'd37,
      PH_CLOC_FLAG     = 6'd38,
      PH_CLOC          = 6'd39,
      PH_TIMING_FLAG   = 6'd40,
      PH_UNITS         = 6'd41,
      PH_SCALE         = 6'd42,
      PH_FIXED         = 6'd43,
      PH_DONE          = 6'd44
   } phase_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_SHORT     = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;
   localparam logic [1:0] STATUS_UNUSED    = 2'd3;

   localparam logic [7:0] AR_IDC_EXPLICIT = 8'd255;

   typedef struct packed {
      logic [4:0]  set_id;
      logic        separate_planes;
      logic [3:0]  frame_num_bits_minus4;
      logic [1:0]  order_count_type;
      logic [3:0]  order_lsb_bits_minus4;
      logic [15:0] width_mbs_minus1;
      logic [15:0] height_units_minus1;
      logic        frames_only;
      logic [31:0] units_per_tick;
      logic [31:0] clock_rate;
   } fields_type;

   typedef struct packed {
      fields_type fields;
      logic       done;
      logic       saturated;
   } parse_out_type;

   // 0 marks an Exp-Golomb element, otherwise the fixed bit count
   function automatic logic [5:0] elem_kind(input phase_type p);
      logic [5:0] k;
      unique case (p)
         PH_SEP_PLANE, PH_BYPASS, PH_MATRIX, PH_LIST_FLAG, PH_ALWAYS_ZERO,
         PH_GAPS, PH_FRAMES_ONLY, PH_MBAFF, PH_DIRECT, PH_CROP_FLAG,
         PH_VUI_FLAG, PH_AR_FLAG, PH_OVERSCAN_FLAG, PH_OVERSCAN_APP,
         PH_VST_FLAG, PH_FULL_RANGE, PH_COLOUR_FLAG, PH_CLOC_FLAG,
         PH_TIMING_FLAG, PH_FIXED:            k = 6'd1;
         PH_VIDEO_FMT:                        k = 6'd3;
         PH_AR_IDC, PH_COLOUR:                k = 6'd8;
         PH_SAR_W, PH_SAR_H:                  k = 6'd16;
         PH_UNITS, PH_SCALE:                  k = 6'd32;
         default:                             k = 6'd0;
      endcase
      return k;
   endfunction

   function automatic logic high_profile(input logic [7:0] p);
      return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
             p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118 || p == 8'd128;
   endfunction

endpackage

/* rtl/h264_sps_header_parser.sv */
// Parses one H.264 sequence parameter set given as RBSP bytes (emulation
// prevention removed), one byte per transaction. The three header bytes are
// taken directly; the eight bits of each later byte walk one at a time
// through the shared syntax decoder before the next byte is taken. The
// byte marked last then loads the result register once that is free, and it
// holds the result while the next parameter set streams in.
module h264_sps_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_profile,
   output logic [4:0]  rsp_set_id,
   output logic        rsp_separate_planes,
   output logic [3:0]  rsp_frame_num_bits_minus4,
   output logic [1:0]  rsp_order_count_type,
   output logic [3:0]  rsp_order_lsb_bits_minus4,
   output logic [15:0] rsp_width_mbs_minus1,
   output logic [15:0] rsp_height_units_minus1,
   output logic        rsp_frames_only,
   output logic [31:0] rsp_units_per_tick,
   output logic [31:0] rsp_clock_rate
);

   typedef enum logic [1:0] {ST_IDLE, ST_SHIFT, ST_EMIT} state_type;

   state_type   state_ff;
   logic [1:0]  hdr_ff;
   logic [7:0]  profile_ff, byte_ff;
   logic [2:0]  bit_cnt_ff;
   logic        last_ff, rsp_valid_ff, rsp_valid_in, clear, accept, emit;
   logic [1:0]  status_ff, status_in;
   logic [7:0]  rsp_profile_ff;
   sph_pkg::fields_type   rsp_fld_ff;
   sph_pkg::parse_out_type parse_out;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign emit         = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign clear        = emit;
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_comb begin
      if (hdr_ff != 2'd3 || !parse_out.done) status_in = sph_pkg::STATUS_SHORT;
      else if (parse_out.saturated)           status_in = sph_pkg::STATUS_SATURATED;
      else                                    status_in = sph_pkg::STATUS_OK;
   end

   sph_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .bit_en    (state_ff == ST_SHIFT),
      .bit_val   (byte_ff[7]),
      .profile   (profile_ff),
      .parse_out (parse_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hdr_ff       <= '0;
         profile_ff   <= '0;
         bit_cnt_ff   <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_ff <= req_last_byte;
                  if (hdr_ff != 2'd3) begin
                     if (hdr_ff == 2'd0) profile_ff <= req_data_byte;
                     hdr_ff   <= hdr_ff + 2'd1;
                     state_ff <= req_last_byte ? ST_EMIT : ST_IDLE;
                  end else begin
                     byte_ff    <= req_data_byte;
                     bit_cnt_ff <= '0;
                     state_ff   <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               // advance one bit per cycle, msb first
               byte_ff    <= {byte_ff[6:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + 3'd1;
               if (bit_cnt_ff == 3'd7) state_ff <= last_ff ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
               // hold until the result register frees up
               if (emit) begin
                  status_ff      <= status_in;
                  rsp_profile_ff <= profile_ff;
                  rsp_fld_ff     <= parse_out.fields;
                  hdr_ff         <= '0;
                  profile_ff     <= '0;
                  state_ff       <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_status                = status_ff;
   assign rsp_profile               = rsp_profile_ff;
   assign rsp_set_id                = rsp_fld_ff.set_id;
   assign rsp_separate_planes       = rsp_fld_ff.separate_planes;
   assign rsp_frame_num_bits_minus4 = rsp_fld_ff.frame_num_bits_minus4;
   assign rsp_order_count_type      = rsp_fld_ff.order_count_type;
   assign rsp_order_lsb_bits_minus4 = rsp_fld_ff.order_lsb_bits_minus4;
   assign rsp_width_mbs_minus1      = rsp_fld_ff.width_mbs_minus1;
   assign rsp_height_units_minus1   = rsp_fld_ff.height_units_minus1;
   assign rsp_frames_only           = rsp_fld_ff.frames_only;
   assign rsp_units_per_tick        = rsp_fld_ff.units_per_tick;
   assign rsp_clock_rate            = rsp_fld_ff.clock_rate;

`ifndef ASSERT_OFF
   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid)
      else $error("result not presented after emit");

   a_shift_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && bit_cnt_ff == 3'd7 && !last_ff) |=> !req_stall)
      else $error("not ready after last bit of a byte");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != sph_pkg::STATUS_UNUSED)
      else $error("undefined status code");

   a_parser_cleared: assert property (@(posedge clock) disable iff (reset)
      emit |=> !parse_out.done && !parse_out.saturated)
      else $error("parser not cleared after result");
`endif

endmodule

/* rtl/sph_parse.sv */
module sph_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clear,
   input  logic                   bit_en,
   input  logic                   bit_val,
   input  logic [7:0]             profile,
   output sph_pkg::parse_out_type parse_out
);

   sph_pkg::phase_type phase_ff, phase_in, target;
   logic [5:0]  lz_ff, lz_in, bl_ff, bl_in, bl_dec;
   logic [32:0] acc_ff, acc_in, fv;
   logic        suf_ff, suf_in, sat_ff, sat_in, chroma3_ff, chroma3_in;
   logic [3:0]  list_ff, list_in, list_inc;
   logic [6:0]  coef_ff, coef_in, coef_inc;
   logic [7:0]  last_scale_ff, last_scale_in, next_scale, delta, mag;
   logic [7:0]  cycle_ff, cycle_in;
   logic [31:0] half;
   logic        fin, go;
   sph_pkg::fields_type fld_ff, fld_in;

   always_comb begin
      phase_in      = phase_ff;
      lz_in         = lz_ff;
      bl_in         = bl_ff;
      acc_in        = acc_ff;
      suf_in        = suf_ff;
      sat_in        = sat_ff;
      chroma3_in    = chroma3_ff;
      list_in       = list_ff;
      coef_in       = coef_ff;
      last_scale_in = last_scale_ff;
      cycle_in      = cycle_ff;
      fld_in        = fld_ff;
      fin           = 1'b0;
      go            = 1'b0;
      fv            = '0;
      target        = phase_ff;
      bl_dec        = (bl_ff != 6'd0) ? bl_ff - 6'd1 : 6'd0;
      half          = fv[32:1];
      mag           = '0;
      delta         = '0;
      next_scale    = '0;
      list_inc      = list_ff + 4'd1;
      coef_inc      = coef_ff + 7'd1;

      if (bit_en && phase_ff != sph_pkg::PH_DONE) begin
         if (sph_pkg::elem_kind(phase_ff) != 6'd0 || suf_ff) begin
            acc_in = {acc_ff[31:0], bit_val};
            bl_in  = bl_dec;
            if (bl_dec == 6'd0) begin
               fin = 1'b1;
               fv  = suf_ff ? acc_in - 33'd1 : acc_in;
            end
         end else if (!bit_val) begin
            lz_in = lz_ff + 6'd1;
            if (lz_in > 6'(sph_pkg::MAX_CODE_BITS)) begin
               sat_in = 1'b1;
               fin    = 1'b1;
               fv     = '1;
            end
         end else if (lz_ff == 6'd0) begin
            fin = 1'b1;
         end else begin
            acc_in = 33'd1;
            bl_in  = lz_ff;
            suf_in = 1'b1;
         end
      end

      half = fv[32:1];
      if (fin) begin
         go     = 1'b1;
         target = sph_pkg::phase_type'(phase_ff + 6'd1);
         unique case (phase_ff)
            sph_pkg::PH_SET_ID: begin
               if (fv > 33'd31) sat_in = 1'b1;
               fld_in.set_id = (fv > 33'd31) ? 5'd31 : fv[4:0];
               target = sph_pkg::high_profile(profile) ? sph_pkg::PH_CHROMA
                                                       : sph_pkg::PH_FRAME_NUM;
            end
            sph_pkg::PH_CHROMA: begin
               if (fv > 33'd3) sat_in = 1'b1;
               if (fv >= 33'd3) begin
                  chroma3_in = 1'b1;
                  target     = sph_pkg::PH_SEP_PLANE;
               end else begin
                  target = sph_pkg::PH_DEPTH_L;
               end
            end
            sph_pkg::PH_SEP_PLANE: begin
               fld_in.separate_planes = fv[0];
               target = sph_pkg::PH_DEPTH_L;
            end
            sph_pkg::PH_MATRIX: begin
               list_in = '0;
               target  = fv[0] ? sph_pkg::PH_LIST_FLAG : sph_pkg::PH_FRAME_NUM;
            end
            sph_pkg::PH_LIST_FLAG: begin
               if (fv[0]) begin
                  last_scale_in = 8'd8;
                  coef_in       = '0;
                  target        = sph_pkg::PH_DELTA;
               end else begin
                  list_in = list_inc;
                  target  = (list_inc >= (chroma3_ff ? 4'd12 : 4'd8))
                            ? sph_pkg::PH_FRAME_NUM : sph_pkg::PH_LIST_FLAG;
               end
            end
            sph_pkg::PH_DELTA: begin
               if (fv[0]) begin
                  if (half >= 32'd127) begin
                     sat_in = 1'b1;
                     delta  = 8'd127;
                  end else begin
                     delta = half[7:0] + 8'd1;
                  end
               end else begin
                  if (half > 32'd128) sat_in = 1'b1;
                  mag   = (half > 32'd128) ? 8'd128 : half[7:0];
                  delta = 8'd0 - mag;
               end
               next_scale = last_scale_ff + delta;
               if (next_scale == 8'd0 ||
                   coef_inc >= ((list_ff < 4'd6) ? 7'd16 : 7'd64)) begin
                  if (next_scale != 8'd0) begin
                     last_scale_in = next_scale;
                     coef_in       = coef_inc;
                  end
                  list_in = list_inc;
                  target  = (list_inc >= (chroma3_ff ? 4'd12 : 4'd8))
                            ? sph_pkg::PH_FRAME_NUM : sph_pkg::PH_LIST_FLAG;
               end else begin
                  last_scale_in = next_scale;
                  coef_in       = coef_inc;
                  target        = sph_pkg::PH_DELTA;
               end
            end
            sph_pkg::PH_FRAME_NUM: begin
               if (fv > 33'd12) sat_in = 1'b1;
               fld_in.frame_num_bits_minus4 = (fv > 33'd12) ? 4'd12 : fv[3:0];
            end
            sph_pkg::PH_POC_TYPE: begin
               if (fv > 33'd2) sat_in = 1'b1;
               fld_in.order_count_type = (fv > 33'd2) ? 2'd2 : fv[1:0];
               target = (fv == 33'd0) ? sph_pkg::PH_POC_LSB :
                        (fv == 33'd1) ? sph_pkg::PH_ALWAYS_ZERO : sph_pkg::PH_NUM_REF;
            end
            sph_pkg::PH_POC_LSB: begin
               if (fv > 33'd12) sat_in = 1'b1;
               fld_in.order_lsb_bits_minus4 = (fv > 33'd12) ? 4'd12 : fv[3:0];
               target = sph_pkg::PH_NUM_REF;
            end
            sph_pkg::PH_CYCLE_N: begin
               if (fv > 33'd255) sat_in = 1'b1;
               cycle_in = (fv > 33'd255) ? 8'd255 : fv[7:0];
               target   = (cycle_in != 8'd0) ? sph_pkg::PH_CYCLE_OFF
                                             : sph_pkg::PH_NUM_REF;
            end
            sph_pkg::PH_CYCLE_OFF: begin
               cycle_in = cycle_ff - 8'd1;
               target   = (cycle_in != 8'd0) ? sph_pkg::PH_CYCLE_OFF
                                             : sph_pkg::PH_NUM_REF;
            end
            sph_pkg::PH_WIDTH: begin
               if (fv > 33'd65535) sat_in = 1'b1;
               fld_in.width_mbs_minus1 = (fv > 33'd65535) ? 16'hFFFF : fv[15:0];
            end
            sph_pkg::PH_HEIGHT: begin
               if (fv > 33'd65535) sat_in = 1'b1;
               fld_in.height_units_minus1 = (fv > 33'd65535) ? 16'hFFFF : fv[15:0];
            end
            sph_pkg::PH_FRAMES_ONLY: begin
               fld_in.frames_only = fv[0];
               target = fv[0] ? sph_pkg::PH_DIRECT : sph_pkg::PH_MBAFF;
            end
            sph_pkg::PH_CROP_FLAG: begin
               coef_in = '0;
               target  = fv[0] ? sph_pkg::PH_CROP : sph_pkg::PH_VUI_FLAG;
            end
            sph_pkg::PH_CROP: begin
               coef_in = coef_inc;
               target  = (coef_inc >= 7'd4) ? sph_pkg::PH_VUI_FLAG : sph_pkg::PH_CROP;
            end
            sph_pkg::PH_VUI_FLAG:
               target = fv[0] ? sph_pkg::PH_AR_FLAG : sph_pkg::PH_DONE;
            sph_pkg::PH_AR_FLAG:
               target = fv[0] ? sph_pkg::PH_AR_IDC : sph_pkg::PH_OVERSCAN_FLAG;
            sph_pkg::PH_AR_IDC:
               target = (fv == {25'd0, sph_pkg::AR_IDC_EXPLICIT})
                        ? sph_pkg::PH_SAR_W : sph_pkg::PH_OVERSCAN_FLAG;
            sph_pkg::PH_OVERSCAN_FLAG:
               target = fv[0] ? sph_pkg::PH_OVERSCAN_APP : sph_pkg::PH_VST_FLAG;
            sph_pkg::PH_VST_FLAG:
               target = fv[0] ? sph_pkg::PH_VIDEO_FMT : sph_pkg::PH_CLOC_FLAG;
            sph_pkg::PH_COLOUR_FLAG: begin
               coef_in = '0;
               target  = fv[0] ? sph_pkg::PH_COLOUR : sph_pkg::PH_CLOC_FLAG;
            end
            sph_pkg::PH_COLOUR: begin
               coef_in = coef_inc;
               target  = (coef_inc >= 7'd3) ? sph_pkg::PH_CLOC_FLAG : sph_pkg::PH_COLOUR;
            end
            sph_pkg::PH_CLOC_FLAG: begin
               coef_in = '0;
               target  = fv[0] ? sph_pkg::PH_CLOC : sph_pkg::PH_TIMING_FLAG;
            end
            sph_pkg::PH_CLOC: begin
               coef_in = coef_inc;
               target  = (coef_inc >= 7'd2) ? sph_pkg::PH_TIMING_FLAG : sph_pkg::PH_CLOC;
            end
            sph_pkg::PH_TIMING_FLAG:
               target = fv[0] ? sph_pkg::PH_UNITS : sph_pkg::PH_DONE;
            sph_pkg::PH_UNITS:
               fld_in.units_per_tick = fv[31:0];
            sph_pkg::PH_SCALE:
               fld_in.clock_rate = fv[31:0];
            default: ;
         endcase
      end

      if (go) begin
         phase_in = target;
         acc_in   = '0;
         lz_in    = '0;
         suf_in   = 1'b0;
         bl_in    = sph_pkg::elem_kind(target);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         phase_ff      <= sph_pkg::PH_SET_ID;
         lz_ff         <= '0;
         bl_ff         <= '0;
         acc_ff        <= '0;
         suf_ff        <= 1'b0;
         sat_ff        <= 1'b0;
         chroma3_ff    <= 1'b0;
         list_ff       <= '0;
         coef_ff       <= '0;
         last_scale_ff <= 8'd8;
         cycle_ff      <= '0;
         fld_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         lz_ff         <= lz_in;
         bl_ff         <= bl_in;
         acc_ff        <= acc_in;
         suf_ff        <= suf_in;
         sat_ff        <= sat_in;
         chroma3_ff    <= chroma3_in;
         list_ff       <= list_in;
         coef_ff       <= coef_in;
         last_scale_ff <= last_scale_in;
         cycle_ff      <= cycle_in;
         fld_ff        <= fld_in;
      end
   end

   assign parse_out.fields    = fld_ff;
   assign parse_out.done      = (phase_ff == sph_pkg::PH_DONE);
   assign parse_out.saturated = sat_ff;

endmodule
